// ----- rtl/core/cba_pkg.sv -----
package cba_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int HALF_W       = 6;
    localparam int MAX_HALF_DEF = 32;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic REG_HALF_WINDOW = 1'b0;

endpackage

// ----- rtl/core/cba_ram.sv -----
module cba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/centered_boxcar_average.sv -----
// Centered boxcar average over a stream of signed 16-bit waveform samples.
// Samples enter on the s_ stream; s_tlast marks the final sample of a waveform.
// Averages leave on the m_ stream; m_tlast marks the final average of a waveform.
// Output i is the sum of samples i-H+1 .. i+H, clipped to the waveform, divided
// by the number of samples in that range and rounded half away from zero.
// H is the half_window register on the APB port (0 acts as 1, values above
// MAX_HALF act as MAX_HALF); writing it restarts the current waveform.
// One transfer at a time is processed: a sample is not accepted until the
// previous one has been through the update and, if it yields an average, the
// one-bit-per-cycle restoring divider and the output register.
// On the last sample up to H more averages drain, each taking one history
// read per retired sample plus one divide.
// Results wait in an output register, so a new sample is accepted while the
// previous average is still waiting; a stalled receiver blocks only the next
// average. Reset clears the running sum, sample count and write pointer and
// sets half_window to 1; the history memory needs no clearing.
module centered_boxcar_average #(
    parameter int MAX_HALF = cba_pkg::MAX_HALF_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [15:0]                 s_tdata,   // in_sample
    input  logic                        s_tlast,   // in_last

    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata,   // out_value
    output logic                        m_tlast,   // out_last

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cba_pkg::PADDR_W-1:0] paddr,
    input  logic [cba_pkg::PDATA_W-1:0] pwdata,
    output logic [cba_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    localparam int SW       = cba_pkg::SAMPLE_W;
    localparam int HAW      = cba_pkg::HALF_W;
    localparam int AW       = $clog2(2 * MAX_HALF);
    localparam int DEPTH    = 2 ** AW;
    localparam int HW       = $clog2(MAX_HALF + 1);
    localparam int CW       = $clog2(2 * MAX_HALF + 1);
    localparam int SUM_W    = SW + CW;
    localparam int NUM_W    = SUM_W + 1;
    localparam int DW       = CW + 1;
    localparam int ITW      = $clog2(NUM_W);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_UPD  = 3'd1;
    localparam logic [2:0] ST_LAST = 3'd2;
    localparam logic [2:0] ST_DCHK = 3'd3;
    localparam logic [2:0] ST_DSUB = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0]              state_reg, state_next;
    logic [HAW-1:0]          half_reg, half_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [CW-1:0]           seen_reg, seen_next;
    logic [AW-1:0]           wp_reg, wp_next;
    logic [SW-1:0]           x_reg, x_next;
    logic                    last_reg, last_next;
    logic                    drain_reg, drain_next;
    logic [HW-1:0]           k_reg, k_next;
    logic signed [SUM_W-1:0] ds_reg, ds_next;
    logic [CW-1:0]           dc_reg, dc_next;
    logic                    neg_reg, neg_next;
    logic [NUM_W-1:0]        num_reg, num_next;
    logic [DW-1:0]           rem_reg, rem_next;
    logic [NUM_W-1:0]        quo_reg, quo_next;
    logic [DW-1:0]           den_reg, den_next;
    logic [ITW-1:0]          it_reg, it_next;
    logic                    olast_reg, olast_next;
    logic                    mvalid_reg, mvalid_next;
    logic [SW-1:0]           mdata_reg, mdata_next;
    logic                    mlast_reg, mlast_next;

    logic                    cfg_wr;
    logic [HW-1:0]           h;
    logic [CW-1:0]           h_c;
    logic [CW-1:0]           win;
    logic                    mem_we;
    logic [AW-1:0]           mem_raddr;
    logic [SW-1:0]           mem_rdata;
    logic signed [SUM_W-1:0] rd_ext;
    logic signed [SUM_W-1:0] x_ext;
    logic signed [SUM_W-1:0] upd_sum;
    logic [CW-1:0]           upd_seen;
    logic [CW-1:0]           want;
    logic [CW-1:0]           kh;
    logic                    div_start;
    logic signed [SUM_W-1:0] div_s;
    logic [CW-1:0]           div_c;
    logic [SUM_W-1:0]        div_mag;
    logic [DW:0]             div_sh;
    logic                    div_ge;
    logic [NUM_W-1:0]        quo_neg;
    logic                    out_free;

    assign cfg_wr = psel && penable && pwrite && (paddr[2] == cba_pkg::REG_HALF_WINDOW);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == cba_pkg::REG_HALF_WINDOW) ?
                    cba_pkg::PDATA_W'(half_reg) : '0;

    always_comb begin
        if (half_reg == '0) begin
            h = HW'(1);
        end else if (half_reg > HAW'(MAX_HALF)) begin
            h = HW'(MAX_HALF);
        end else begin
            h = HW'(half_reg);
        end
    end

    assign h_c = CW'(h);
    assign win = CW'({h, 1'b0});

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tlast  = mlast_reg;
    assign out_free = !mvalid_reg || m_tready;

    assign rd_ext  = {{(SUM_W-SW){mem_rdata[SW-1]}}, mem_rdata};
    assign x_ext   = {{(SUM_W-SW){x_reg[SW-1]}}, x_reg};
    assign upd_sum = ((seen_reg >= win) ? (sum_reg - rd_ext) : sum_reg) + x_ext;
    assign upd_seen = (seen_reg < win) ? seen_reg + 1'b1 : seen_reg;

    assign kh   = CW'(k_reg) - 1'b1 + h_c;
    assign want = (kh < seen_reg) ? kh : seen_reg;

    assign mem_we    = (state_reg == ST_UPD);
    assign mem_raddr = (state_reg == ST_IDLE) ? wp_reg - AW'(win) : wp_reg - AW'(dc_reg);

    assign div_mag = (div_s < 0) ? SUM_W'(-div_s) : SUM_W'(div_s);
    assign div_sh  = {rem_reg, num_reg[NUM_W-1]};
    assign div_ge  = div_sh >= {1'b0, den_reg};
    assign quo_neg = -quo_reg;

    cba_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_hist (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (wp_reg),
        .wdata (x_reg),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb begin
        state_next  = state_reg;
        half_next   = half_reg;
        sum_next    = sum_reg;
        seen_next   = seen_reg;
        wp_next     = wp_reg;
        x_next      = x_reg;
        last_next   = last_reg;
        drain_next  = drain_reg;
        k_next      = k_reg;
        ds_next     = ds_reg;
        dc_next     = dc_reg;
        olast_next  = olast_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        mlast_next  = mlast_reg;
        div_start   = 1'b0;
        div_s       = sum_reg;
        div_c       = seen_reg;

        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    x_next     = s_tdata;
                    last_next  = s_tlast;
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                sum_next  = upd_sum;
                seen_next = upd_seen;
                wp_next   = wp_reg + 1'b1;
                if (upd_seen > h_c) begin
                    div_start  = 1'b1;
                    div_s      = upd_sum;
                    div_c      = upd_seen;
                    olast_next = 1'b0;
                    state_next = ST_DIV;
                end else if (last_reg) begin
                    state_next = ST_LAST;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_LAST: begin
                ds_next    = sum_reg;
                dc_next    = seen_reg;
                k_next     = (h_c < seen_reg) ? h : HW'(seen_reg);
                drain_next = 1'b1;
                state_next = ST_DCHK;
            end
            ST_DCHK: begin
                if (dc_reg > want) begin
                    state_next = ST_DSUB;
                end else begin
                    div_start  = 1'b1;
                    div_s      = ds_reg;
                    div_c      = dc_reg;
                    olast_next = (k_reg == HW'(1));
                    state_next = ST_DIV;
                end
            end
            ST_DSUB: begin
                ds_next    = ds_reg - rd_ext;
                dc_next    = dc_reg - 1'b1;
                state_next = ST_DCHK;
            end
            ST_DIV: begin
                if (it_reg == '0) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    mvalid_next = 1'b1;
                    mdata_next  = neg_reg ? quo_neg[SW-1:0] : quo_reg[SW-1:0];
                    mlast_next  = olast_reg;
                    if (drain_reg) begin
                        if (k_reg == HW'(1)) begin
                            drain_next = 1'b0;
                            last_next  = 1'b0;
                            sum_next   = '0;
                            seen_next  = '0;
                            wp_next    = '0;
                            state_next = ST_IDLE;
                        end else begin
                            k_next     = k_reg - 1'b1;
                            state_next = ST_DCHK;
                        end
                    end else if (last_reg) begin
                        state_next = ST_LAST;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_wr) begin
            half_next = pwdata[HAW-1:0];
            sum_next  = '0;
            seen_next = '0;
            wp_next   = '0;
        end
    end

    always_comb begin
        neg_next = neg_reg;
        num_next = num_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        den_next = den_reg;
        it_next  = it_reg;
        if (div_start) begin
            neg_next = (div_s < 0);
            num_next = NUM_W'({div_mag, 1'b0}) + NUM_W'(div_c);
            den_next = DW'({div_c, 1'b0});
            rem_next = '0;
            quo_next = '0;
            it_next  = ITW'(NUM_W - 1);
        end else if (state_reg == ST_DIV) begin
            rem_next = div_ge ? DW'(div_sh - {1'b0, den_reg}) : div_sh[DW-1:0];
            quo_next = {quo_reg[NUM_W-2:0], div_ge};
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            if (it_reg != '0) begin
                it_next = it_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            half_reg   <= HAW'(1);
            sum_reg    <= '0;
            seen_reg   <= '0;
            wp_reg     <= '0;
            last_reg   <= 1'b0;
            drain_reg  <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            half_reg   <= half_next;
            sum_reg    <= sum_next;
            seen_reg   <= seen_next;
            wp_reg     <= wp_next;
            last_reg   <= last_next;
            drain_reg  <= drain_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg     <= x_next;
        k_reg     <= k_next;
        ds_reg    <= ds_next;
        dc_reg    <= dc_next;
        olast_reg <= olast_next;
        mdata_reg <= mdata_next;
        mlast_reg <= mlast_next;
        neg_reg   <= neg_next;
        num_reg   <= num_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        den_reg   <= den_next;
        it_reg    <= it_next;
    end

endmodule

// ----- tb/cba_checker.sv -----
`timescale 1ns / 1ps

module cba_checker (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [15:0]                 s_tdata,   // in_sample
    input  logic                        s_tlast,   // in_last

    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [15:0]                 m_tdata,   // out_value
    input  logic                        m_tlast,   // out_last

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cba_pkg::PADDR_W-1:0] paddr,
    input  logic [cba_pkg::PDATA_W-1:0] pwdata,
    input  logic                        pready,

    output int                          failures,
    output int                          averages_owed,
    output int                          averages_checked
);

    localparam logic [cba_pkg::PADDR_W-1:0] HALF_ADDR =
        cba_pkg::PADDR_W'(4 * cba_pkg::REG_HALF_WINDOW);

    typedef struct packed {
        logic [cba_pkg::SAMPLE_W-1:0] value;
        logic                         last;
    } average_t;

    average_t                            pending_averages[$];
    logic signed [cba_pkg::SAMPLE_W-1:0] hist [64];
    logic [cba_pkg::HALF_W-1:0]          half_setting;
    logic [5:0]                          wr_ptr;
    int                                  run_sum;
    int                                  seen;

    function automatic int effective_half();
        if (half_setting == 0) return 1;
        if (half_setting > cba_pkg::MAX_HALF_DEF) return cba_pkg::MAX_HALF_DEF;
        return int'(half_setting);
    endfunction

    function automatic logic [cba_pkg::SAMPLE_W-1:0] rounded_mean(input int total,
                                                                  input int count);
        int mag;
        int q;
        mag = (total < 0) ? -total : total;
        q = (2 * mag + count) / (2 * count);
        return (total < 0) ? cba_pkg::SAMPLE_W'(-q) : cba_pkg::SAMPLE_W'(q);
    endfunction

    task automatic restart_waveform();
        run_sum = 0;
        seen = 0;
        wr_ptr = '0;
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        failures++;
    endtask

    task automatic predict_averages(input logic signed [cba_pkg::SAMPLE_W-1:0] sample,
                                    input logic last_in);
        int h;
        int span;
        int part_sum;
        int part_cnt;
        int keep;
        h = effective_half();
        span = 2 * h;
        if (seen >= span) run_sum -= hist[6'(wr_ptr - span)];
        hist[wr_ptr] = sample;
        wr_ptr = wr_ptr + 1'b1;
        if (seen < span) seen++;
        run_sum += sample;
        if (seen > h) pending_averages.push_back('{rounded_mean(run_sum, seen), 1'b0});
        if (last_in) begin
            // The tail of the waveform drains, the window shrinking from the old end.
            part_sum = run_sum;
            part_cnt = seen;
            for (int k = (h < seen) ? h : seen; k > 0; k--) begin
                keep = (k - 1 + h < seen) ? k - 1 + h : seen;
                while (part_cnt > keep) begin
                    part_sum -= hist[6'(wr_ptr - part_cnt)];
                    part_cnt--;
                end
                pending_averages.push_back('{rounded_mean(part_sum, part_cnt), k == 1});
            end
            restart_waveform();
        end
    endtask

    task automatic check_average();
        average_t want;
        if (pending_averages.size() == 0) begin
            report_mismatch($sformatf("average %0d (last %0b) with none owed",
                                      $signed(m_tdata), m_tlast));
            return;
        end
        want = pending_averages.pop_front();
        averages_checked++;
        if (m_tdata !== want.value)
            report_mismatch($sformatf("average %0d, wanted %0d",
                                      $signed(m_tdata), $signed(want.value)));
        if (m_tlast !== want.last)
            report_mismatch($sformatf("m_tlast %0b, wanted %0b on average %0d",
                                      m_tlast, want.last, $signed(want.value)));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            half_setting = cba_pkg::HALF_W'(1);
            restart_waveform();
            pending_averages.delete();
            failures = 0;
            averages_checked = 0;
            averages_owed = 0;
        end else begin
            if (m_tvalid && m_tready) check_average();
            if (s_tvalid && s_tready) predict_averages(s_tdata, s_tlast);
            if (psel && penable && pwrite && pready && paddr == HALF_ADDR) begin
                half_setting = pwdata[cba_pkg::HALF_W-1:0];
                restart_waveform();
            end
            averages_owed = pending_averages.size();
        end
    end

endmodule

// ----- tb/tb_centered_boxcar_average.sv -----
`timescale 1ns / 1ps

module tb_centered_boxcar_average;

    localparam logic [cba_pkg::PADDR_W-1:0] HALF_ADDR =
        cba_pkg::PADDR_W'(4 * cba_pkg::REG_HALF_WINDOW);
    localparam int SETTLE_CYCLES = 80;

    logic                         aclk;
    logic                         aresetn;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [15:0]                  s_tdata;   // in_sample
    logic                         s_tlast;   // in_last
    logic                         m_tvalid;
    logic                         m_tready;
    logic [15:0]                  m_tdata;   // out_value
    logic                         m_tlast;   // out_last
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [cba_pkg::PADDR_W-1:0]  paddr;
    logic [cba_pkg::PDATA_W-1:0]  pwdata;
    logic [cba_pkg::PDATA_W-1:0]  prdata;
    logic                         pready;

    int failures;
    int averages_owed;
    int averages_checked;
    int burst_left;
    int samples_sent;
    int waves_closed;
    int settings_written;

    centered_boxcar_average i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    cba_checker i_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tlast          (s_tlast),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tlast          (m_tlast),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .pready           (pready),
        .failures         (failures),
        .averages_owed    (averages_owed),
        .averages_checked (averages_checked)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    initial begin
        #5_000_000;
        $display("Run timed out with %0d averages still owed.", averages_owed);
        $display("RESULT: ERROR");
        $finish;
    end

    // The receiver switches between steady, patchy and mostly stalled stretches.
    initial begin
        int mode;
        int left;
        m_tready = 1'b0;
        mode = 0;
        left = 0;
        forever begin
            @(negedge aclk);
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 150);
            end
            left--;
            case (mode)
                0: begin
                    m_tready <= 1'b1;
                end
                1: begin
                    m_tready <= ($urandom_range(0, 3) != 0);
                end
                2: begin
                    m_tready <= ($urandom_range(0, 1) != 0);
                end
                default: begin
                    m_tready <= ($urandom_range(0, 15) == 0);
                end
            endcase
        end
    end

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($signed($urandom_range(0, 8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_sample(input logic [15:0] value, input logic last_in);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last_in;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        samples_sent++;
        if (last_in) waves_closed++;
    endtask

    task automatic send_wave(input int len, input bit close);
        for (int i = 0; i < len; i++) send_sample(pick_sample(), close && i == len - 1);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (averages_owed != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_half(input logic [cba_pkg::HALF_W-1:0] value);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= HALF_ADDR;
        pwdata  <= cba_pkg::PDATA_W'(value);
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_written++;
    endtask

    initial begin
        logic [cba_pkg::HALF_W-1:0] settings [8];
        int h;
        int budget;
        int len;
        bit close;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        burst_left = 0;
        samples_sent = 0;
        waves_closed = 0;
        settings_written = 0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset half window: full-scale extremes, a lone sample, rounding of halves.
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h8000, 1'b1);
        send_sample(16'h8000, 1'b1);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0001, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b1);
        // A zero setting behaves as one.
        write_half(6'd0);
        send_sample(16'h0003, 1'b0);
        send_sample(16'hFFFE, 1'b1);
        // A waveform shorter than the half window.
        write_half(6'd3);
        send_sample(16'h0005, 1'b0);
        send_sample(16'hFFFA, 1'b1);
        // An oversized setting, then a write that cuts the open waveform short.
        write_half(6'd63);
        send_sample(16'h0064, 1'b0);
        send_sample(16'hFF9C, 1'b0);
        send_sample(16'h0007, 1'b0);
        write_half(6'd2);
        send_sample(16'h5555, 1'b0);
        send_sample(16'hAAAA, 1'b0);
        send_sample(16'h0001, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h7FFF, 1'b1);

        settings[0] = 6'd2;
        settings[1] = 6'd1;
        settings[2] = 6'd63;
        settings[3] = 6'd4;
        settings[4] = 6'd0;
        settings[5] = 6'd32;
        settings[6] = 6'd3;
        settings[7] = cba_pkg::HALF_W'($urandom_range(5, 31));
        foreach (settings[p]) begin
            write_half(settings[p]);
            h = (settings[p] == 0) ? 1 :
                (settings[p] > cba_pkg::MAX_HALF_DEF) ? cba_pkg::MAX_HALF_DEF :
                int'(settings[p]);
            budget = 0;
            if (settings[p] == 6'd63) begin
                send_wave(2 * h + 3, 1'b1);
                budget = 2 * h + 3;
            end
            while (budget < 8) begin
                len = (h >= 16) ? $urandom_range(1, 10) : $urandom_range(1, 2 * h + 5);
                close = (budget + len < 8) || ($urandom_range(0, 2) != 0);
                send_wave(len, close);
                budget += len;
            end
        end

        settle();
        $display("Sent %0d samples in %0d closed waveforms across %0d half-window writes.",
                 samples_sent, waves_closed, settings_written);
        $display("Checked %0d averages with %0d mismatches.", averages_checked, failures);
        if (failures == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
